[hdl/oile_pkg.sv]
// ----------------------------------------------------------------------------
// oile_pkg
// Shared types, codes and helpers of the ordered integer list engine.
// ----------------------------------------------------------------------------
package oile_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
   localparam int LVL      = $clog2(CAPACITY);

   // request kinds
   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_DELETE = 3'd1;
   localparam logic [2:0] KIND_READ   = 3'd2;
   localparam logic [2:0] KIND_FIND   = 3'd3;
   localparam logic [2:0] KIND_SORT   = 3'd4;
   localparam logic [2:0] KIND_MODE   = 3'd5;

   // order modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_ASC  = 2'd1;
   localparam logic [1:0] MODE_DESC = 2'd2;
   localparam logic [1:0] MODE_BAD  = 2'd3;

   // status codes
   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_MISS  = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // cell commands
   localparam logic [2:0] CMD_HOLD      = 3'd0;
   localparam logic [2:0] CMD_INSERT    = 3'd1;
   localparam logic [2:0] CMD_DELETE    = 3'd2;
   localparam logic [2:0] CMD_TRANSPOSE = 3'd3;
   localparam logic [2:0] CMD_TAG_INIT  = 3'd4;

   // compare keys for the transposition sort
   localparam logic [1:0] KEY_ASC  = 2'd1;
   localparam logic [1:0] KEY_DESC = 2'd2;
   localparam logic [1:0] KEY_TAG  = 2'd3;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
      logic [7:0]         index;
      logic [1:0]         order;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] result_value;
      logic [8:0]         count;
   } rsp_type;

   typedef struct packed {
      logic [31:0]      data;
      logic [IDX_W-1:0] tag;
   } cell_word_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [1:0]  key;
      logic [1:0]  mode;
      logic        phase;
      logic        match_eq;
      logic [31:0] value;
   } cell_ctl_type;

   // true when a sits left of b and the pair must swap
   function automatic logic out_of_order(input cell_word_type a, input cell_word_type b,
                                         input logic [1:0] key);
      logic res;
      case (key)
         KEY_ASC:  res = $signed(b.data) < $signed(a.data);
         KEY_DESC: res = $signed(a.data) < $signed(b.data);
         KEY_TAG:  res = a.tag < b.tag;
         default:  res = 1'b0;
      endcase
      return res;
   endfunction

endpackage

[hdl/oile_cell.sv]
// ----------------------------------------------------------------------------
// oile_cell
// One list slot: holds a value and a tag, compares against the broadcast
// value and trades words with its two neighbors.
// ----------------------------------------------------------------------------
module oile_cell (
   input  logic                      clock,
   input  oile_pkg::cell_ctl_type    ctl,
   input  logic [oile_pkg::IDX_W-1:0] cell_pos,
   input  logic                      valid,
   input  logic                      left_valid,
   input  logic                      right_valid,
   input  oile_pkg::cell_word_type   left_word,
   input  oile_pkg::cell_word_type   right_word,
   input  logic                      stop_self,
   input  logic                      stop_left,
   output oile_pkg::cell_word_type   word,
   output logic                      hit
);
   import oile_pkg::*;

   cell_word_type word_ff;
   cell_word_type word_in;
   logic          ins_cond;
   logic          is_left;
   logic          swap_r;
   logic          swap_l;

   assign word = word_ff;

   always_comb begin
      case (ctl.mode)
         MODE_ASC:  ins_cond = !($signed(ctl.value) < $signed(word_ff.data));
         MODE_DESC: ins_cond = !($signed(word_ff.data) < $signed(ctl.value));
         default:   ins_cond = 1'b1;
      endcase
      hit = ctl.match_eq ? (valid && (word_ff.data == ctl.value)) : !(valid && ins_cond);
   end

   assign is_left = (cell_pos[0] == ctl.phase);
   assign swap_r  = valid && right_valid && is_left &&
                    out_of_order(word_ff, right_word, ctl.key);
   assign swap_l  = valid && left_valid && !is_left &&
                    out_of_order(left_word, word_ff, ctl.key);

   always_comb begin
      word_in = word_ff;
      case (ctl.cmd)
         CMD_INSERT: begin
            if (stop_self) begin
               if (stop_left) word_in = left_word;
               else word_in = '{data: ctl.value, tag: word_ff.tag};
            end
         end
         CMD_DELETE: begin
            if (stop_self) word_in = right_word;
         end
         CMD_TRANSPOSE: begin
            if (swap_r) word_in = right_word;
            else if (swap_l) word_in = left_word;
         end
         CMD_TAG_INIT: word_in.tag = cell_pos;
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

[hdl/oile_prefix.sv]
// ----------------------------------------------------------------------------
// oile_prefix
// Inclusive prefix OR across the cell row, head first, log-depth.
// ----------------------------------------------------------------------------
module oile_prefix (
   input  logic [oile_pkg::CAPACITY-1:0] vec,
   output logic [oile_pkg::CAPACITY-1:0] pre
);
   import oile_pkg::*;

   logic [CAPACITY-1:0] stg [0:LVL];

   always_comb begin
      stg[0] = vec;
      for (int l = 0; l < LVL; l++) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (i >= (1 << l)) stg[l+1][i] = stg[l][i] | stg[l][i - (1 << l)];
            else stg[l+1][i] = stg[l][i];
         end
      end
   end

   assign pre = stg[LVL];

endmodule

[hdl/ordered_integer_list_engine_core.sv]
// ----------------------------------------------------------------------------
// ordered_integer_list_engine_core
// Bounded list of signed 32-bit values kept in a row of cells, with order
// modes, insert, delete, read, find, sort and mode change.
// ----------------------------------------------------------------------------
// Each request is taken while the engine is idle and executed in the next
// cycle. Insert, delete, read and find then return to idle, the response
// registered at the end of the execute state, which is held for as long as
// the response register is still occupied. The value is broadcast to every
// cell, the cells compare in parallel and a prefix OR picks the insert or
// delete point, from which on every cell shifts together. Sort and mode
// changes that reorder run an odd-even transposition pass per cycle over the
// cells: count passes (at least one), after a tagging state that numbers the
// positions when an ascending list is reversed to descending or back. A sort
// or mode change that reorders nothing goes straight to the finish state,
// which also waits while the response register is still occupied. A new
// request is taken only when the engine is idle; a finished response may
// still wait in the output register meanwhile. Cell storage is not reset;
// the state, the count, the mode and the response valid flag are.
// ----------------------------------------------------------------------------
module ordered_integer_list_engine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  oile_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output oile_pkg::rsp_type rsp_data
);
   import oile_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_TAG  = 3'd2;
   localparam logic [2:0] ST_SORT = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0]       state_ff, state_in;
   req_type          req_hold_ff, req_hold_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       mode_ff, mode_in;
   logic [1:0]       key_ff, key_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   cell_ctl_type        ctl;
   cell_word_type       cw [0:CAPACITY-1];
   logic [CAPACITY-1:0] hit;
   logic [CAPACITY-1:0] pre;
   logic [CAPACITY-1:0] vld;

   logic             slot_free;
   logic             found;
   logic [CMP_W-1:0] rd_ext;
   logic             rd_ok;
   logic [IDX_W-1:0] rd_pos;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // occupancy of each slot
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) vld[i] = (CNT_W'(i) < count_ff);
   end

   // the row of cells
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      cell_word_type lw, rw;
      logic          lv, rv, sl;
      if (gi == 0) begin : g_head
         assign lw = '0;
         assign lv = 1'b0;
         assign sl = 1'b0;
      end else begin : g_mid
         assign lw = cw[gi-1];
         assign lv = 1'b1;
         assign sl = pre[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
         assign rw = '0;
         assign rv = 1'b0;
      end else begin : g_nxt
         assign rw = cw[gi+1];
         assign rv = vld[gi+1];
      end
      oile_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .cell_pos    (IDX_W'(gi)),
         .valid       (vld[gi]),
         .left_valid  (lv),
         .right_valid (rv),
         .left_word   (lw),
         .right_word  (rw),
         .stop_self   (pre[gi]),
         .stop_left   (sl),
         .word        (cw[gi]),
         .hit         (hit[gi])
      );
   end

   // first match or insert point
   oile_prefix u_prefix (
      .vec (hit),
      .pre (pre)
   );

   assign found  = pre[CAPACITY-1];
   assign rd_ext = CMP_W'(req_hold_ff.index);
   assign rd_ok  = rd_ext < CMP_W'(count_ff);
   assign rd_pos = IDX_W'(rd_ext);

   always_comb begin
      state_in     = state_ff;
      req_hold_in  = req_hold_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      ctl.cmd      = CMD_HOLD;
      ctl.key      = key_ff;
      ctl.mode     = mode_ff;
      ctl.phase    = cnt_ff[0];
      ctl.match_eq = (req_hold_ff.kind != KIND_INSERT);
      ctl.value    = req_hold_ff.value;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_hold_in = req_data;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (req_hold_ff.kind)
               KIND_SORT: begin
                  if (req_hold_ff.order == MODE_ASC || req_hold_ff.order == MODE_DESC) begin
                     key_in   = req_hold_ff.order;
                     cnt_in   = '0;
                     state_in = ST_SORT;
                  end else begin
                     state_in = ST_FIN;
                  end
               end
               KIND_MODE: begin
                  if (req_hold_ff.order == MODE_BAD || req_hold_ff.order == mode_ff) begin
                     state_in = ST_FIN;
                  end else begin
                     mode_in = req_hold_ff.order;
                     cnt_in  = '0;
                     if (mode_ff == MODE_NONE) begin
                        key_in   = req_hold_ff.order;
                        state_in = ST_SORT;
                     end else if (req_hold_ff.order != MODE_NONE) begin
                        state_in = ST_TAG;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
               end
               default: begin
                  if (slot_free) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.status       = STAT_DONE;
                     rsp_in.result_value = '0;
                     state_in            = ST_IDLE;
                     case (req_hold_ff.kind)
                        KIND_INSERT: begin
                           if (count_ff == CNT_W'(CAPACITY)) begin
                              rsp_in.status = STAT_FULL;
                           end else begin
                              ctl.cmd  = CMD_INSERT;
                              count_in = count_ff + 1'b1;
                           end
                        end
                        KIND_DELETE: begin
                           if (found) begin
                              ctl.cmd  = CMD_DELETE;
                              count_in = count_ff - 1'b1;
                           end else begin
                              rsp_in.status = STAT_MISS;
                           end
                        end
                        KIND_READ: begin
                           if (rd_ok) rsp_in.result_value = cw[rd_pos].data;
                           else rsp_in.status = STAT_MISS;
                        end
                        KIND_FIND: begin
                           if (found) rsp_in.result_value = req_hold_ff.value;
                           else rsp_in.status = STAT_MISS;
                        end
                        default: rsp_in.status = STAT_DONE;
                     endcase
                     rsp_in.count = 9'(count_in);
                  end
               end
            endcase
         end
         ST_TAG: begin
            // number the slots so reversal becomes a sort on position
            ctl.cmd  = CMD_TAG_INIT;
            key_in   = KEY_TAG;
            state_in = ST_SORT;
         end
         ST_SORT: begin
            ctl.cmd = CMD_TRANSPOSE;
            cnt_in  = cnt_ff + 1'b1;
            if ((CNT_W+1)'(cnt_ff) + 1'b1 >= (CNT_W+1)'(count_ff)) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STAT_DONE;
               rsp_in.result_value = '0;
               rsp_in.count        = 9'(count_ff);
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mode_ff      <= MODE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_hold_ff <= req_hold_in;
      key_ff      <= key_in;
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list count beyond capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STAT_FULL |-> count_ff == CNT_W'(CAPACITY))
      else $error("full status with free slots");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending response lost or changed");
`endif

endmodule

[test/ordered_integer_list_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// ordered_integer_list_engine_core_tb
// Self-checking bench for the ordered integer list engine: a directed table
// of requests covering modes, extremes and error statuses, then random
// traffic scored against a behavioral list model, with random idling on both
// channels, a long response stall and a drain pause.
// ----------------------------------------------------------------------------
module ordered_integer_list_engine_core_tb;
   import oile_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 600;
   localparam int RANDOM_ITEMS   = 330;
   localparam int STALL_CYCLES   = 300;

   // kinds the engine ignores
   localparam logic [2:0] KIND_SPARE_A = 3'd6;
   localparam logic [2:0] KIND_SPARE_B = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   ordered_integer_list_engine_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // behavioral list state
   logic signed [31:0] list_vals [CAPACITY];
   int                 list_len;
   logic [1:0]         list_mode;

   rsp_type expected_rsps [$];
   int      error_count;
   int      idle_cycles;
   bit      stall_hold;
   bit      stim_done;

   typedef struct {
      req_type req;
      bit      has_expect;
      rsp_type rsp;
   } table_row_type;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic bit wrong_order(input logic signed [31:0] a,
                                      input logic signed [31:0] b, input logic [1:0] ord);
      // a sits before b but should follow it
      return (ord == MODE_ASC) ? (b < a) : (a < b);
   endfunction

   function automatic void sort_values(input logic [1:0] ord);
      logic signed [31:0] v;
      int j;
      if (ord != MODE_ASC && ord != MODE_DESC) return;
      for (int i = 1; i < list_len; i++) begin
         v = list_vals[i];
         j = i;
         while (j > 0 && wrong_order(list_vals[j-1], v, ord)) begin
            list_vals[j] = list_vals[j-1];
            j--;
         end
         list_vals[j] = v;
      end
   endfunction

   function automatic int locate(input logic signed [31:0] v);
      for (int i = 0; i < list_len; i++)
         if (list_vals[i] == v) return i;
      return -1;
   endfunction

   // computes the response of one request and advances the list state
   function automatic rsp_type apply_request(input req_type r);
      rsp_type o;
      int pos;
      logic signed [31:0] t;
      o = '0;
      o.status = STAT_DONE;
      case (r.kind)
         KIND_INSERT: begin
            if (list_len >= CAPACITY) o.status = STAT_FULL;
            else begin
               pos = list_len;
               if (list_mode == MODE_ASC || list_mode == MODE_DESC) begin
                  pos = 0;
                  while (pos < list_len && !wrong_order(list_vals[pos], r.value, list_mode))
                     pos++;
               end
               for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
               list_vals[pos] = r.value;
               list_len++;
            end
         end
         KIND_DELETE: begin
            pos = locate(r.value);
            if (pos < 0) o.status = STAT_MISS;
            else begin
               for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
               list_len--;
            end
         end
         KIND_READ: begin
            if (r.index < list_len) o.result_value = list_vals[r.index];
            else o.status = STAT_MISS;
         end
         KIND_FIND: begin
            pos = locate(r.value);
            if (pos < 0) o.status = STAT_MISS;
            else o.result_value = list_vals[pos];
         end
         KIND_SORT: sort_values(r.order);
         KIND_MODE: begin
            if (r.order != MODE_BAD && r.order != list_mode) begin
               if (list_mode == MODE_NONE) sort_values(r.order);
               else if (r.order != MODE_NONE) begin
                  for (int i = 0, j = list_len - 1; i < j; i++, j--) begin
                     t = list_vals[i];
                     list_vals[i] = list_vals[j];
                     list_vals[j] = t;
                  end
               end
               list_mode = r.order;
            end
         end
         default: ;
      endcase
      o.count = list_len[8:0];
      return o;
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return (list_len > 0) ? list_vals[$urandom_range(0, list_len - 1)] : 32'sd0;
         3: return $signed(32'($urandom_range(0, 15)) - 32'd8);
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      int k;
      r.value = pick_value();
      r.index = (list_len > 0 && $urandom_range(0, 3) != 0) ?
                8'($urandom_range(0, list_len - 1)) : 8'($urandom());
      r.order = 2'($urandom_range(0, 3));
      k = $urandom_range(0, 99);
      // inserts dominate so the list grows toward full
      if (k < 45)      r.kind = KIND_INSERT;
      else if (k < 62) r.kind = KIND_DELETE;
      else if (k < 74) r.kind = KIND_READ;
      else if (k < 86) r.kind = KIND_FIND;
      else if (k < 91) r.kind = KIND_SORT;
      else if (k < 98) r.kind = KIND_MODE;
      else             r.kind = ($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B;
      return r;
   endfunction

   // one request on the input channel, held until accepted; valid stays up
   // after acceptance only when the next request follows in the same cycle
   task automatic send_request(input req_type r, input bit has_expect, input rsp_type want);
      rsp_type predicted;
      int      gap;
      gap = $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = apply_request(r);
      if (has_expect && predicted !== want)
         report_mismatch("table row", 64'(predicted), 64'(want));
      expected_rsps.push_back(predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // response side: random stall per response, or a long hold when asked
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (stall_hold) begin
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            stall_hold = 1'b0;
         end
         n = $urandom_range(0, 17);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && !stall_hold);
      end
   end

   // response scoring
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("unexpected response at %0t", $realtime);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.result_value !== want.result_value)
               report_mismatch("result_value", 64'(rsp_data.result_value),
                               64'(want.result_value));
            if (rsp_data.count !== want.count)
               report_mismatch("count", 64'(rsp_data.count), 64'(want.count));
         end
      end
   end

   // watchdog on cycles without any accepted request or response, paused during the long hold
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (!stall_hold) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic table_row_type row(input logic [2:0] kind, input logic signed [31:0] v,
                                         input logic [7:0] idx, input logic [1:0] ord,
                                         input bit chk = 0, input logic [1:0] st = 0,
                                         input logic signed [31:0] rv = 0,
                                         input logic [8:0] cnt = 0);
      table_row_type t;
      t.req = '{kind: kind, value: v, index: idx, order: ord};
      t.has_expect = chk;
      t.rsp = '{status: st, result_value: rv, count: cnt};
      return t;
   endfunction

   initial begin
      table_row_type rows [$];
      req_type r;
      rsp_type none;
      int      sent;
      error_count = 0;
      idle_cycles = 0;
      stall_hold  = 1'b0;
      stim_done   = 1'b0;
      list_len    = 0;
      list_mode   = MODE_NONE;
      none        = '0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, every kind and each corner
      rows.push_back(row(KIND_READ,   0, 8'd0,   MODE_NONE, 1, STAT_MISS, 0, 0));
      rows.push_back(row(KIND_DELETE, 5, 0,      MODE_NONE, 1, STAT_MISS, 0, 0));
      rows.push_back(row(KIND_FIND,   5, 0,      MODE_NONE, 1, STAT_MISS, 0, 0));
      rows.push_back(row(KIND_INSERT, 32'sh7fff_ffff, 0, MODE_NONE, 1, STAT_DONE, 0, 1));
      rows.push_back(row(KIND_INSERT, 32'sh8000_0000, 0, MODE_NONE, 1, STAT_DONE, 0, 2));
      rows.push_back(row(KIND_INSERT, -1, 0, MODE_NONE));
      rows.push_back(row(KIND_INSERT, 1,  0, MODE_NONE));
      rows.push_back(row(KIND_READ,   0, 8'd0, MODE_NONE, 1, STAT_DONE, 32'sh7fff_ffff, 4));
      rows.push_back(row(KIND_READ,   0, 8'd255, MODE_NONE, 1, STAT_MISS, 0, 4));
      rows.push_back(row(KIND_SORT,   0, 0, MODE_NONE));
      rows.push_back(row(KIND_SORT,   0, 0, MODE_BAD));
      rows.push_back(row(KIND_SORT,   0, 0, MODE_DESC));
      rows.push_back(row(KIND_MODE,   0, 0, MODE_BAD));
      rows.push_back(row(KIND_MODE,   0, 0, MODE_ASC));
      rows.push_back(row(KIND_READ,   0, 8'd0, MODE_NONE, 1, STAT_DONE, 32'sh8000_0000, 4));
      rows.push_back(row(KIND_INSERT, 1, 0, MODE_NONE));
      rows.push_back(row(KIND_MODE,   0, 0, MODE_ASC));
      rows.push_back(row(KIND_MODE,   0, 0, MODE_DESC));
      rows.push_back(row(KIND_INSERT, 0, 0, MODE_NONE));
      rows.push_back(row(KIND_INSERT, 32'sh8000_0000, 0, MODE_NONE));
      rows.push_back(row(KIND_FIND,   1, 0, MODE_NONE, 1, STAT_DONE, 1, 7));
      rows.push_back(row(KIND_DELETE, 1, 0, MODE_NONE, 1, STAT_DONE, 0, 6));
      rows.push_back(row(KIND_MODE,   0, 0, MODE_NONE));
      rows.push_back(row(KIND_SPARE_A, -1, 8'hff, MODE_BAD, 1, STAT_DONE, 0, 6));
      rows.push_back(row(KIND_SPARE_B, 0, 0, MODE_NONE, 1, STAT_DONE, 0, 6));
      foreach (rows[i]) send_request(rows[i].req, rows[i].has_expect, rows[i].rsp);

      // fill to capacity under a long response stall, then hit the full status
      stall_hold = 1'b1;
      while (list_len < CAPACITY) begin
         r = '{kind: KIND_INSERT, value: $signed($urandom()), index: 8'($urandom()),
               order: 2'($urandom())};
         send_request(r, 0, none);
      end
      r.kind = KIND_INSERT;
      send_request(r, 1, '{status: STAT_FULL, result_value: 0, count: 9'd256});
      send_request('{kind: KIND_READ, value: 0, index: 8'd255, order: MODE_NONE}, 0, none);
      send_request('{kind: KIND_MODE, value: 0, index: 0, order: MODE_DESC}, 0, none);
      send_request('{kind: KIND_MODE, value: 0, index: 0, order: MODE_ASC}, 0, none);
      // sender pause until everything has come back
      wait_drained();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // occasionally empty the list so small sizes dominate
         if (list_len > 40 && $urandom_range(0, 3) == 0)
            while (list_len > 0) begin
               send_request('{kind: KIND_DELETE, value: list_vals[$urandom_range(0,
                            list_len - 1)], index: 8'($urandom()), order: 2'($urandom())},
                            0, none);
               sent++;
            end
         send_request(random_request(), 0, none);
         sent++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[filelist.f]
hdl/oile_pkg.sv
hdl/oile_cell.sv
hdl/oile_prefix.sv
hdl/ordered_integer_list_engine_core.sv
test/ordered_integer_list_engine_core_tb.sv
